@@ design/iptrie_pkg.sv @@
`timescale 1ns / 1ps

package iptrie_pkg;

  // Address field width and prefix-length width
  localparam int ADDR_BITS = 32;
  localparam int LEN_BITS  = 6;

  // Width of the value field on the ports
  localparam int FIELD_VALUE_BITS = 32;

  // Defaults for the top-level parameters
  localparam int DEF_NODE_COUNT = 4096;
  localparam int DEF_VALUE_BITS = 32;

  // Item kinds
  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  // Result status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage

@@ design/iptrie_node_mem.sv @@
`timescale 1ns / 1ps

// Simple dual-port node store: one write, one registered read per cycle.
module iptrie_node_mem #(
  parameter int DEPTH = iptrie_pkg::DEF_NODE_COUNT,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/ipv4_binary_trie_lpm.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake                      Fields
// -------   ---------  -----------------------------  -----------------------------------
// item      in         start & !busy at clock edge    kind, address, prefix_len, entry_value
// result    out        done, one cycle, no backpress  hit, match_value, status
//
// An item walks the trie one level per cycle: insert walks down to level prefix_len
// (length saturated at 32), lookup to level 32 or to the first missing child; the
// result is registered after the walk. The loop is the node-memory read of the next
// child, one per level. Reset (synchronous) empties the trie: the root lives in flops
// and every other node is written whole when allocated, so no clearing pass is needed.
// busy is high only during the walk; a new item may be taken while done is high.
// The receiver cannot stall: each result is valid for exactly one cycle.
module ipv4_binary_trie_lpm #(
  parameter int NODE_COUNT = iptrie_pkg::DEF_NODE_COUNT,
  parameter int VALUE_BITS = iptrie_pkg::DEF_VALUE_BITS
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  output logic                                    busy,
  input  logic                                    kind,
  input  logic [iptrie_pkg::ADDR_BITS-1:0]        address,
  input  logic [iptrie_pkg::LEN_BITS-1:0]         prefix_len,
  input  logic [iptrie_pkg::FIELD_VALUE_BITS-1:0] entry_value,
  output logic                                    done,
  output logic                                    hit,
  output logic [iptrie_pkg::FIELD_VALUE_BITS-1:0] match_value,
  output logic                                    status
);

  import iptrie_pkg::*;

  // Node index width; the use count needs one more bit to hold NODE_COUNT itself.
  localparam int IW = $clog2(NODE_COUNT);
  localparam int UW = IW + 1;

  // One trie node. A child link of 0 means no child: the root is nobody's child.
  typedef struct packed {
    logic                  hv;
    logic [VALUE_BITS-1:0] val;
    logic [IW-1:0]         c1;
    logic [IW-1:0]         c0;
  } entry_t;

  localparam int EW = $bits(entry_t);

  typedef enum logic {ST_IDLE, ST_WALK} state_t;

  state_t                state;
  logic [IW-1:0]         node;       // node under the walk
  logic [LEN_BITS-1:0]   level;      // trie level of node
  logic                  fresh;      // node was just allocated, not yet in memory
  logic                  found;      // lookup has a match so far
  logic [VALUE_BITS-1:0] best;       // value of the deepest match so far
  logic                  kind_r;
  logic [ADDR_BITS-1:0]  addr_r;
  logic [LEN_BITS-1:0]   len_r;      // walk depth: saturated length, or 32 on lookup
  logic [VALUE_BITS-1:0] val_r;
  entry_t                root;       // node 0, held in flops so reset clears it
  logic [UW-1:0]         nodes_used;

  // Memory side
  logic          mem_we;
  logic          mem_re;
  logic [IW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;
  entry_t        rd_entry;

  // Walk datapath
  entry_t                cur;
  entry_t                wr_entry;
  logic                  wr_en;
  logic                  bit_b;
  logic [IW-1:0]         nxt;
  logic [IW-1:0]         new_idx;
  logic                  at_end;
  logic                  pool_full;
  logic                  found_n;
  logic [VALUE_BITS-1:0] best_n;
  logic [VALUE_BITS+31:0] best_wide;
  logic                  step;       // move to an existing child
  logic                  alloc;      // link a fresh child and move to it
  logic                  finish;
  logic                  fin_hit;
  logic                  fin_status;
  logic                  accept;

  assign accept   = start && !busy;
  assign busy     = (state == ST_WALK);
  assign rd_entry = mem_rdata;

  // Current node: a fresh node is empty, the root comes from flops.
  assign cur = fresh ? '0 : ((node == '0) ? root : rd_entry);

  // Address bit at this level, counted from bit 31 down.
  assign bit_b     = addr_r[~level[4:0]];
  assign nxt       = bit_b ? cur.c1 : cur.c0;
  assign new_idx   = nodes_used[IW-1:0];
  assign at_end    = (level == len_r);
  assign pool_full = (nodes_used >= UW'(NODE_COUNT));

  // Lookup: fold in this node's value before deciding to go on.
  assign found_n   = found || cur.hv;
  assign best_n    = cur.hv ? cur.val : best;
  assign best_wide = (VALUE_BITS + 32)'(best_n);

  always_comb begin
    wr_en      = 1'b0;
    wr_entry   = cur;
    step       = 1'b0;
    alloc      = 1'b0;
    finish     = 1'b0;
    fin_hit    = 1'b0;
    fin_status = STATUS_OK;
    if (state == ST_WALK) begin
      if (kind_r == KIND_INSERT) begin
        if (at_end) begin
          // Final node takes the value, replacing any earlier one.
          wr_en        = 1'b1;
          wr_entry.hv  = 1'b1;
          wr_entry.val = val_r;
          finish       = 1'b1;
        end else if (nxt != '0) begin
          step = 1'b1;
        end else if (pool_full) begin
          // Write back as is, so a fresh node lands in memory empty.
          wr_en      = 1'b1;
          finish     = 1'b1;
          fin_status = STATUS_FULL;
        end else begin
          wr_en = 1'b1;
          alloc = 1'b1;
          if (bit_b) begin
            wr_entry.c1 = new_idx;
          end else begin
            wr_entry.c0 = new_idx;
          end
        end
      end else begin
        if (at_end || nxt == '0) begin
          finish  = 1'b1;
          fin_hit = found_n;
        end else begin
          step = 1'b1;
        end
      end
    end
  end

  assign mem_we    = wr_en && (node != '0);
  assign mem_re    = step;
  assign mem_raddr = nxt;

  iptrie_node_mem #(
    .DEPTH (NODE_COUNT),
    .WIDTH (EW),
    .AW    (IW)
  ) u_node_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (node),
    .wdata (wr_entry),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      root       <= '0;
      nodes_used <= UW'(1);
      done       <= 1'b0;
      fresh      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (wr_en && node == '0) begin
        root <= wr_entry;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state  <= ST_WALK;
            node   <= '0;
            level  <= '0;
            fresh  <= 1'b0;
            found  <= 1'b0;
            best   <= '0;
            kind_r <= kind;
            addr_r <= address;
            val_r  <= VALUE_BITS'(entry_value);
            if (kind == KIND_INSERT) begin
              len_r <= (prefix_len > LEN_BITS'(ADDR_BITS)) ? LEN_BITS'(ADDR_BITS)
                                                           : prefix_len;
            end else begin
              len_r <= LEN_BITS'(ADDR_BITS);
            end
          end
        end
        ST_WALK: begin
          found <= found_n;
          best  <= best_n;
          if (step) begin
            node  <= nxt;
            level <= level + LEN_BITS'(1);
            fresh <= 1'b0;
          end else if (alloc) begin
            node       <= new_idx;
            level      <= level + LEN_BITS'(1);
            fresh      <= 1'b1;
            nodes_used <= nodes_used + UW'(1);
          end
          if (finish) begin
            state       <= ST_IDLE;
            done        <= 1'b1;
            hit         <= fin_hit;
            match_value <= fin_hit ? best_wide[FIELD_VALUE_BITS-1:0] : '0;
            status      <= fin_status;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A result strobe only follows the last cycle of a walk.
  a_done_after_walk: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_WALK))
    else $error("result without a walk");

  // Pool count stays between the root alone and a full pool.
  a_pool_range: assert property (@(posedge clk) disable iff (rst)
    nodes_used >= UW'(1) && nodes_used <= UW'(NODE_COUNT))
    else $error("node count out of range");

  // Memory writes go to allocated non-root nodes only.
  a_write_target: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (UW'(node) < nodes_used))
    else $error("node write outside the pool");

  // A full report is never a hit, and a miss reports zero.
  a_result_codes: assert property (@(posedge clk) disable iff (rst)
    done |-> (!(hit && status == STATUS_FULL) && (hit || match_value == '0)))
    else $error("inconsistent result fields");

endmodule
